// ----- rtl/eos_pkg.sv -----
// shared constants, types and codes for the euler orbit step core
// no dependencies
package eos_pkg;

	localparam int WORD_BITS = 48;
	localparam int FRAC_BITS = 32;
	localparam int CFG_BITS  = 47;

	// step size about 0.01, gm is four pi squared (39.4784176) in unsigned Q15.32
	localparam logic [CFG_BITS-1:0] STEP_RESET = 47'd42949673;
	localparam logic [CFG_BITS-1:0] GM_RESET   = 47'd169558512490;

	localparam logic CFG_STEP = 1'b0;
	localparam logic CFG_GM   = 1'b1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_R2,
		ST_R3,
		ST_PV,
		ST_PH,
		ST_PG,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/eos_if.sv -----
// valid/ready channel interfaces for command items and result items
// depends on nothing but the word width parameter
interface eos_in_if #(parameter int W = 48);
	logic                valid;
	logic                ready;
	logic                func;
	logic signed [W-1:0] load_px;
	logic signed [W-1:0] load_py;
	logic signed [W-1:0] load_pz;
	logic signed [W-1:0] load_vx;
	logic signed [W-1:0] load_vy;
	logic signed [W-1:0] load_vz;

	modport source (output valid, func, load_px, load_py, load_pz, load_vx, load_vy,
		load_vz, input ready);
	modport sink (input valid, func, load_px, load_py, load_pz, load_vx, load_vy,
		load_vz, output ready);
endinterface

interface eos_out_if #(parameter int W = 48);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_px;
	logic signed [W-1:0] out_py;
	logic signed [W-1:0] out_pz;
	logic signed [W-1:0] out_vx;
	logic signed [W-1:0] out_vy;
	logic signed [W-1:0] out_vz;
	logic        [1:0]   status;

	modport source (output valid, out_px, out_py, out_pz, out_vx, out_vy, out_vz, status,
		input ready);
	modport sink (input valid, out_px, out_py, out_pz, out_vx, out_vy, out_vz, status,
		output ready);
endinterface

// ----- rtl/euler_orbit_step_core.sv -----
// euler orbit step core: a load item is written to the state and echoed as its result, a
// step item runs through the serial multiplier (B = 49 multiplier bits at the default
// widths), the bit-by-bit square root and the restoring divider (N = 174 dividend bits);
// one item is worked at a time
// asynchronous reset clears position and velocity to zero and restores the default
// step size and gravitational parameter
module euler_orbit_step_core #(
	parameter int WORD_BITS = eos_pkg::WORD_BITS,
	parameter int FRAC_BITS = eos_pkg::FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [eos_pkg::CFG_BITS-1:0] cfg_data,
	eos_in_if.sink                       req,
	eos_out_if.source                    rsp
);
	import eos_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int C    = CFG_BITS;
	localparam int SQW  = 2 * W + 2;
	localparam int RW   = SQW / 2;
	localparam int AW   = (2 * W + 2 > W + C) ? 2 * W + 2 : W + C;
	localparam int BW   = (W + 1 > C) ? W + 1 : C;
	localparam int PW   = AW + BW;
	localparam int R2W  = 2 * W + 2;
	localparam int R3W  = 3 * W + 3;
	localparam int TW   = W + C;
	localparam int NW   = W + 2 * C + F;
	localparam int MAGW = (NW > PW) ? NW : PW;

	function automatic logic [W-1:0] mag_f(input logic [W-1:0] x);
		mag_f = x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// returns {saturated, value}
	function automatic logic [W:0] sat_f(input logic [W-1:0] p, input logic neg,
		input logic [MAGW-1:0] m);
		logic signed [W+1:0] sum;
		logic signed [W+1:0] smax;
		logic signed [W+1:0] smin;
		logic                big;
		smax = {3'b000, {(W-1){1'b1}}};
		smin = {3'b111, {(W-1){1'b0}}};
		big  = |m[MAGW-1:W];
		if (neg) sum = $signed({{2{p[W-1]}}, p}) - $signed({2'b00, m[W-1:0]});
		else     sum = $signed({{2{p[W-1]}}, p}) + $signed({2'b00, m[W-1:0]});
		if (big) sat_f = {1'b1, neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
		else if (sum > smax) sat_f = {1'b1, 1'b0, {(W-1){1'b1}}};
		else if (sum < smin) sat_f = {1'b1, 1'b1, {(W-1){1'b0}}};
		else sat_f = {1'b0, sum[W-1:0]};
	endfunction

	state_t state_q, state_d;
	logic   go_q, go_d;

	logic [C-1:0]   step_q, gm_q;
	logic [W-1:0]   pos_q [0:2];
	logic [W-1:0]   vel_q [0:2];
	logic [W-1:0]   npos_q [0:2];
	logic [W-1:0]   nvel_q [0:2];
	logic [1:0]     axis_q;
	logic [SQW-1:0] s_q;
	logic [RW-1:0]  r_q;
	logic [R2W-1:0] r2_q;
	logic [R3W-1:0] r3_q;
	logic [TW-1:0]  t_q;
	logic [NW-1:0]  num_q;
	logic           sat_q;

	logic           ov_q;
	logic [W-1:0]   o_q [0:5];
	logic [1:0]     ost_q;

	logic           mul_go, mul_done, sqrt_go, sqrt_done, div_go, div_done;
	logic [AW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic [PW-1:0]  prod;
	logic [RW-1:0]  root;
	logic [NW-1:0]  quot;
	logic [W:0]     pos_sum, vel_sum;
	logic           accept;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !ov_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				mul_a = AW'(mag_f(pos_q[axis_q]));
				mul_b = BW'(mag_f(pos_q[axis_q]));
			end
			ST_R2: begin
				mul_a = AW'(r_q);
				mul_b = BW'(r_q);
			end
			ST_R3: begin
				mul_a = AW'(r2_q);
				mul_b = BW'(r_q);
			end
			ST_PV: begin
				mul_a = AW'(mag_f(vel_q[axis_q]));
				mul_b = BW'(step_q);
			end
			ST_PH: begin
				mul_a = AW'(mag_f(pos_q[axis_q]));
				mul_b = BW'(step_q);
			end
			ST_PG: begin
				mul_a = AW'(t_q);
				mul_b = BW'(gm_q);
			end
			default: ;
		endcase
	end

	assign mul_go  = go_q && (state_q != ST_SQRT) && (state_q != ST_DIV);
	assign sqrt_go = go_q && (state_q == ST_SQRT);
	assign div_go  = go_q && (state_q == ST_DIV);

	eos_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(prod)
	);

	eos_sqrt #(.IW(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_go), .x(s_q), .done(sqrt_done), .root(root)
	);

	eos_div #(.NW(NW), .DW(R3W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(num_q), .den(r3_q),
		.done(div_done), .quot(quot)
	);

	// position increment is |v|*h with the fraction shifted out
	assign pos_sum = sat_f(pos_q[axis_q], vel_q[axis_q][W-1], MAGW'(prod >> F));
	assign vel_sum = sat_f(vel_q[axis_q], !pos_q[axis_q][W-1], MAGW'(quot));

	always_comb begin
		state_d = state_q;
		go_d    = 1'b0;
		case (state_q)
			ST_IDLE: if (accept && req.func == FUNC_STEP) begin
				state_d = ST_SQ;
				go_d    = 1'b1;
			end
			ST_SQ: if (mul_done) begin
				state_d = (axis_q == 2'd2) ? ST_SQRT : ST_SQ;
				go_d    = 1'b1;
			end
			ST_SQRT: if (sqrt_done) begin
				state_d = (root == '0) ? ST_IDLE : ST_R2;
				go_d    = (root != '0);
			end
			ST_R2: if (mul_done) begin
				state_d = ST_R3;
				go_d    = 1'b1;
			end
			ST_R3: if (mul_done) begin
				state_d = ST_PV;
				go_d    = 1'b1;
			end
			ST_PV: if (mul_done) begin
				state_d = ST_PH;
				go_d    = 1'b1;
			end
			ST_PH: if (mul_done) begin
				state_d = ST_PG;
				go_d    = 1'b1;
			end
			ST_PG: if (mul_done) begin
				state_d = ST_DIV;
				go_d    = 1'b1;
			end
			ST_DIV: if (div_done) begin
				state_d = (axis_q == 2'd2) ? ST_FIN : ST_PV;
				go_d    = (axis_q != 2'd2);
			end
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			gm_q   <= GM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_STEP) step_q <= cfg_data;
			else                       gm_q   <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
			ov_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept && req.func == FUNC_LOAD) begin
					pos_q[0] <= req.load_px;
					pos_q[1] <= req.load_py;
					pos_q[2] <= req.load_pz;
					vel_q[0] <= req.load_vx;
					vel_q[1] <= req.load_vy;
					vel_q[2] <= req.load_vz;
					o_q[0]   <= req.load_px;
					o_q[1]   <= req.load_py;
					o_q[2]   <= req.load_pz;
					o_q[3]   <= req.load_vx;
					o_q[4]   <= req.load_vy;
					o_q[5]   <= req.load_vz;
					ost_q    <= STAT_OK;
					ov_q     <= 1'b1;
				end else if (accept) begin
					axis_q <= 2'd0;
					s_q    <= '0;
					sat_q  <= 1'b0;
				end
				ST_SQ: if (mul_done) begin
					s_q    <= s_q + SQW'(prod);
					axis_q <= axis_q + 2'd1;
				end
				ST_SQRT: if (sqrt_done) begin
					r_q <= root;
					if (root == '0) begin
						// zero radius: state held and echoed
						for (int i = 0; i < 3; i++) begin
							o_q[i]     <= pos_q[i];
							o_q[i + 3] <= vel_q[i];
						end
						ost_q <= STAT_ZERO;
						ov_q  <= 1'b1;
					end
				end
				ST_R2: if (mul_done) r2_q <= R2W'(prod);
				ST_R3: if (mul_done) begin
					r3_q   <= R3W'(prod);
					axis_q <= 2'd0;
				end
				ST_PV: if (mul_done) begin
					npos_q[axis_q] <= pos_sum[W-1:0];
					sat_q          <= sat_q | pos_sum[W];
				end
				ST_PH: if (mul_done) t_q <= TW'(prod);
				ST_PG: if (mul_done) num_q <= {prod[W+2*C-1:0], {F{1'b0}}};
				ST_DIV: if (div_done) begin
					nvel_q[axis_q] <= vel_sum[W-1:0];
					sat_q          <= sat_q | vel_sum[W];
					axis_q         <= axis_q + 2'd1;
				end
				ST_FIN: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i]   <= npos_q[i];
						vel_q[i]   <= nvel_q[i];
						o_q[i]     <= npos_q[i];
						o_q[i + 3] <= nvel_q[i];
					end
					ost_q <= sat_q ? STAT_SAT : STAT_OK;
					ov_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid  = ov_q;
	assign rsp.out_px = o_q[0];
	assign rsp.out_py = o_q[1];
	assign rsp.out_pz = o_q[2];
	assign rsp.out_vx = o_q[3];
	assign rsp.out_vy = o_q[4];
	assign rsp.out_vz = o_q[5];
	assign rsp.status = ost_q;
endmodule

// ----- rtl/eos_mul.sv -----
// shift-add multiplier, one bit of b per cycle, unsigned operands
// standalone, used by the euler orbit step core
module eos_mul #(
	parameter int AW = 98,
	parameter int BW = 49
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] p
);
	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW + 1);

	logic [PW-1:0] acc_q, a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PW'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[PW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

// ----- rtl/eos_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned operands
// standalone, used by the euler orbit step core
module eos_div #(
	parameter int NW = 174,
	parameter int DW = 147
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q, quot_q;
	logic [DW-1:0] den_q, rem_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits dw bits
			rem_q  <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			quot_q <= {quot_q[NW-2:0], ge};
			num_q  <= {num_q[NW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ----- rtl/eos_sqrt.sv -----
// bit-by-bit integer square root, one root bit per cycle
// standalone, used by the euler orbit step core
module eos_sqrt #(
	parameter int IW = 98
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IW-1:0]   x,
	output logic            done,
	output logic [IW/2-1:0] root
);
	localparam int RW = IW / 2;
	localparam int CW = $clog2(RW + 1);

	logic [IW-1:0] x_q;
	logic [RW-1:0] root_q;
	logic [RW:0]   rem_q;
	logic [RW+2:0] cand, trial;
	logic          ge;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	assign cand  = {rem_q, x_q[IW-1:IW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (RW+1)'(cand - trial) : (RW+1)'(cand);
			root_q <= {root_q[RW-2:0], ge};
			x_q    <= {x_q[IW-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ----- tb/euler_orbit_step_core_tb.sv -----
// testbench for euler_orbit_step_core: directed table, then phases of random load/step items
// checked against an in-bench predictor of the fixed point euler step
// depends on eos_pkg, eos_in_if, eos_out_if and the core
`timescale 1ns / 100ps

module euler_orbit_step_core_tb;
	import eos_pkg::*;

	localparam int W = WORD_BITS;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int NUM_PHASES = 8;
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE = 48'h1_0000_0000;

	typedef logic [W-1:0] word_t;

	typedef struct {
		logic func;
		word_t ld [6];
	} cmd_t;

	typedef struct {
		word_t w [6];
		logic [1:0] status;
	} orbit_t;

	typedef struct {
		cmd_t cmd;
		bit typed;
		orbit_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_STEP;
	logic [CFG_BITS-1:0] cfg_data = '0;

	eos_in_if #(.W(W)) req_if ();
	eos_out_if #(.W(W)) rsp_if ();

	euler_orbit_step_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #1 clk = ~clk;

	// predictor copy of the block state
	word_t orbit_st [6];
	logic [CFG_BITS-1:0] h_q = STEP_RESET;
	logic [CFG_BITS-1:0] gm_q = GM_RESET;

	orbit_t expected_orbits [$];
	int errors = 0;
	int cycles = 0;
	int idle_mode = 0;
	string field_names [6] = '{"out_px", "out_py", "out_pz", "out_vx", "out_vy", "out_vz"};

	function automatic logic [255:0] mag_of(word_t p);
		return p[W-1] ? 256'(word_t'(-p)) : 256'(p);
	endfunction

	function automatic logic [255:0] isqrt(logic [255:0] n);
		logic [255:0] res;
		logic [255:0] t;
		res = '0;
		for (int b = 127; b >= 0; b--) begin
			t = res | (256'd1 << b);
			if (t * t <= n)
				res = t;
		end
		return res;
	endfunction

	// add a signed magnitude in offset binary, clamping at the word limits
	function automatic word_t sat_sum(word_t p, logic neg, logic [255:0] m, inout logic sat);
		logic [255:0] b;
		logic [255:0] lim;
		lim = 256'((64'd1 << W) - 1);
		if (m >= (256'd1 << 64))
			m = (256'd1 << 64) - 1;
		b = 256'({~p[W-1], p[W-2:0]});
		if (!neg) begin
			if (m > lim - b) begin
				b = lim;
				sat = 1'b1;
			end else
				b = b + m;
		end else begin
			if (m > b) begin
				b = '0;
				sat = 1'b1;
			end else
				b = b - m;
		end
		return {~b[W-1], b[W-2:0]};
	endfunction

	function automatic orbit_t advance_orbit(cmd_t c);
		orbit_t o;
		logic [255:0] s, r, r3, a;
		word_t nw [6];
		logic sat;
		o.status = STAT_OK;
		if (c.func == FUNC_LOAD) begin
			orbit_st = c.ld;
		end else begin
			s = '0;
			for (int i = 0; i < 3; i++)
				s = s + mag_of(orbit_st[i]) * mag_of(orbit_st[i]);
			r = isqrt(s);
			if (r == 0) begin
				o.status = STAT_ZERO;
			end else begin
				sat = 1'b0;
				r3 = r * r * r;
				for (int i = 0; i < 3; i++) begin
					a = (mag_of(orbit_st[3+i]) * 256'(h_q)) >> FRAC_BITS;
					nw[i] = sat_sum(orbit_st[i], orbit_st[3+i][W-1], a, sat);
					a = ((mag_of(orbit_st[i]) * 256'(h_q) * 256'(gm_q)) << FRAC_BITS) / r3;
					nw[3+i] = sat_sum(orbit_st[3+i], !orbit_st[i][W-1], a, sat);
				end
				orbit_st = nw;
				if (sat)
					o.status = STAT_SAT;
			end
		end
		o.w = orbit_st;
		return o;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: check accepted items, then pick ready for the next edge
	initial rsp_if.ready = 1'b0;
	always @(posedge clk) begin
		orbit_t e;
		if (rsp_if.valid && rsp_if.ready) begin
			if (expected_orbits.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				e = expected_orbits.pop_front();
				if (rsp_if.out_px !== e.w[0]) begin
					$error("%s exp %h got %h", field_names[0], e.w[0], rsp_if.out_px);
					errors++;
				end
				if (rsp_if.out_py !== e.w[1]) begin
					$error("%s exp %h got %h", field_names[1], e.w[1], rsp_if.out_py);
					errors++;
				end
				if (rsp_if.out_pz !== e.w[2]) begin
					$error("%s exp %h got %h", field_names[2], e.w[2], rsp_if.out_pz);
					errors++;
				end
				if (rsp_if.out_vx !== e.w[3]) begin
					$error("%s exp %h got %h", field_names[3], e.w[3], rsp_if.out_vx);
					errors++;
				end
				if (rsp_if.out_vy !== e.w[4]) begin
					$error("%s exp %h got %h", field_names[4], e.w[4], rsp_if.out_vy);
					errors++;
				end
				if (rsp_if.out_vz !== e.w[5]) begin
					$error("%s exp %h got %h", field_names[5], e.w[5], rsp_if.out_vz);
					errors++;
				end
				if (rsp_if.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp_if.status);
					errors++;
				end
			end
		end
		if (!arst_n)
			rsp_if.ready <= 1'b0;
		else if (idle_mode == 2)
			rsp_if.ready <= $urandom_range(99) >= 85;
		else if (idle_mode == 3)
			rsp_if.ready <= $urandom_range(99) >= 15;
		else
			rsp_if.ready <= 1'b1;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.func = FUNC_LOAD;
		req_if.load_px = '0;
		req_if.load_py = '0;
		req_if.load_pz = '0;
		req_if.load_vx = '0;
		req_if.load_vy = '0;
		req_if.load_vz = '0;
		orbit_st = '{default: '0};
	end

	task automatic send_item(cmd_t c, bit typed, orbit_t typed_res);
		orbit_t o;
		int pct;
		pct = (idle_mode == 1) ? 85 : (idle_mode == 3) ? 15 : 0;
		if (pct != 0 && $urandom_range(99) < pct) begin
			req_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < pct);
		end
		req_if.valid <= 1'b1;
		req_if.func <= c.func;
		req_if.load_px <= c.ld[0];
		req_if.load_py <= c.ld[1];
		req_if.load_pz <= c.ld[2];
		req_if.load_vx <= c.ld[3];
		req_if.load_vy <= c.ld[4];
		req_if.load_vz <= c.ld[5];
		do
			@(posedge clk);
		while (!req_if.ready);
		o = advance_orbit(c);
		expected_orbits.push_back(typed ? typed_res : o);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (expected_orbits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [CFG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_STEP)
			h_q = val;
		else
			gm_q = val;
	endtask

	function automatic word_t rand_full();
		return word_t'({$urandom, $urandom});
	endfunction

	// mostly orbit-sized values, magnitude spread over many octaves
	function automatic word_t rand_orbit();
		word_t m;
		m = rand_full() >> $urandom_range(W - 1, 12);
		return $urandom_range(1) ? -m : m;
	endfunction

	function automatic cmd_t make_load(bit full);
		cmd_t c;
		c.func = FUNC_LOAD;
		for (int i = 0; i < 6; i++)
			c.ld[i] = full ? rand_full() : rand_orbit();
		return c;
	endfunction

	function automatic cmd_t make_step();
		cmd_t c;
		c.func = FUNC_STEP;
		for (int i = 0; i < 6; i++)
			c.ld[i] = rand_full();
		return c;
	endfunction

	function automatic row_t load_row(word_t a0, word_t a1, word_t a2, word_t a3, word_t a4,
		word_t a5);
		row_t r;
		r.cmd.func = FUNC_LOAD;
		r.cmd.ld = '{a0, a1, a2, a3, a4, a5};
		r.typed = 1'b1;
		r.res.w = r.cmd.ld;
		r.res.status = STAT_OK;
		return r;
	endfunction

	function automatic row_t step_row();
		row_t r;
		r.cmd = make_step();
		r.typed = 1'b0;
		r.res.w = '{default: '0};
		r.res.status = STAT_OK;
		return r;
	endfunction

	row_t stim_table [$];

	initial begin
		row_t r;
		cmd_t c;
		int steps_left;
		logic [CFG_BITS-1:0] h_set [NUM_PHASES];
		logic [CFG_BITS-1:0] gm_set [NUM_PHASES];

		h_set = '{STEP_RESET, '0, '1, 47'($urandom) >> 4, STEP_RESET, 47'(ONE), '1,
			47'({$urandom, $urandom})};
		gm_set = '{GM_RESET, '1, '0, 47'({$urandom, $urandom}) >> 8, GM_RESET, '1,
			47'({$urandom, $urandom}), '1};

		// step straight after reset: zero radius, zero state held
		r = step_row();
		r.typed = 1'b1;
		r.res.status = STAT_ZERO;
		stim_table.push_back(r);
		stim_table.push_back(load_row(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
		stim_table.push_back(step_row());
		stim_table.push_back(load_row(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN));
		stim_table.push_back(step_row());
		// zero position with moving body: state held
		stim_table.push_back(load_row('0, '0, '0, WMAX, WMIN, ONE));
		r = step_row();
		r.typed = 1'b1;
		r.res.w = '{'0, '0, '0, WMAX, WMIN, ONE};
		r.res.status = STAT_ZERO;
		stim_table.push_back(r);
		// circular earth-like orbit, 1 au at 2 pi au per year
		stim_table.push_back(load_row(ONE, '0, '0, '0, 48'd26986075409, '0));
		repeat (5) stim_table.push_back(step_row());
		// one lsb of radius: enormous pull, saturates
		stim_table.push_back(load_row(48'd1, '0, '0, '0, '0, '0));
		stim_table.push_back(step_row());
		stim_table.push_back(load_row(WMAX, '0, '0, WMAX, '0, '0));
		stim_table.push_back(step_row());
		stim_table.push_back(load_row(-ONE, ONE >> 1, ONE >> 2, -48'd3000000000, 48'd7,
			WMIN));
		stim_table.push_back(step_row());
		stim_table.push_back(load_row('0, '0, -48'd1, '0, '0, '0));
		stim_table.push_back(step_row());

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_item(stim_table[i].cmd, stim_table[i].typed, stim_table[i].res);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				write_cfg(CFG_STEP, h_set[ph]);
				write_cfg(CFG_GM, gm_set[ph]);
			end
			idle_mode = ph % 4;
			steps_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off until the core has returned everything
				if (n == ITEMS_PER_PHASE / 2) begin
					req_if.valid <= 1'b0;
					while (expected_orbits.size() != 0)
						@(posedge clk);
				end
				if (steps_left > 0) begin
					c = make_step();
					steps_left--;
				end else if ($urandom_range(9) < 2) begin
					c = ($urandom_range(1) != 0) ? make_load(1'b1) : make_step();
				end else begin
					c = make_load(1'b0);
					steps_left = $urandom_range(2);
				end
				send_item(c, 1'b0, r.res);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
